FILE: rtl/core/maog_pkg.sv
// types and constants shared by the moving-average outlier gate
`timescale 1ns / 1ps

package maog_pkg;

  localparam int TOF_W      = 16;
  localparam int THR_W      = 10;
  localparam int MM_W       = 14;
  localparam int SPD_W      = 9;
  localparam int ALERT_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_TDATA_W = 48;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_YELLOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RED       = 3'd4;

  localparam logic [THR_W-1:0] THR_RST    = 10'd150;
  localparam logic [MM_W-1:0]  BASE_RST   = 14'd2000;
  localparam logic [SPD_W-1:0] SPEED_RST  = 9'd343;
  localparam logic [MM_W-1:0]  YELLOW_RST = 14'd100;
  localparam logic [MM_W-1:0]  RED_RST    = 14'd200;

  // input kinds
  localparam logic ACT_MEASURE = 1'b0;
  localparam logic ACT_PRELOAD = 1'b1;

  // alert codes
  localparam logic [ALERT_W-1:0] ALERT_GREEN  = 2'd0;
  localparam logic [ALERT_W-1:0] ALERT_YELLOW = 2'd1;
  localparam logic [ALERT_W-1:0] ALERT_RED    = 2'd2;

  localparam logic [MM_W-1:0] DIST_MAX = 14'd16383;

  // tof * speed / 2000 as a reciprocal multiply, exact for 25-bit products
  localparam int    PROD_W     = TOF_W + SPD_W;
  localparam int    DIST_DIV   = 2000;
  localparam int    DIV_SHIFT  = 36;
  localparam longint DIV_MUL   = ((longint'(1) << DIV_SHIFT) + DIST_DIV - 1) / DIST_DIV;
  localparam int    DIV_MUL_W  = 26;
  localparam int    DIST_Q_W   = PROD_W + DIV_MUL_W - DIV_SHIFT;

  typedef struct packed {
    logic               accepted;
    logic [TOF_W-1:0]   mean;
    logic [MM_W-1:0]    gap;
    logic [MM_W-1:0]    depth;
    logic [ALERT_W-1:0] alert;
  } out_item_t;

endpackage

FILE: rtl/core/moving_average_outlier_gate_depth.sv
// moving-average outlier gate with flood depth and alert classification
`timescale 1ns / 1ps

// Takes one time-of-flight transaction per clock. A preload (tuser high) writes the sample
// into the ring unchecked and gives no result; a measure (tuser low) is tested against the
// ring mean once the ring has filled, enters the ring when accepted and gives one result
// carrying the mean before the update, the air gap, the depth and the alert level. The ring
// sits in a synchronous memory whose next entry is prefetched, so the running sum takes one
// read-modify-write per clock; a new transaction can follow every cycle while in_tready is
// high. A result goes through s1, s2 and s3 and is then queued; in_tready drops while
// queued results and in-flight transactions number eight. The ring clears at reset in the
// same cycle via per-entry valid bits. Config is taken at any cycle (cfg_ready is high).
module moving_average_outlier_gate_depth #(
  parameter int WINDOW = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [maog_pkg::TOF_W-1:0]        in_tdata,   // [15:0] tof_us
  input  logic                              in_tuser,   // [0] action
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [maog_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [15:0] baseline_mean_us,
                                                        // [29:16] distance_mm,
                                                        // [43:30] depth_mm,
                                                        // [45:44] alert_level
  output logic                              out_tuser,  // [0] accepted
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [maog_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [maog_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import maog_pkg::*;

  localparam int PTR_W      = $clog2(WINDOW);
  localparam int SUM_W      = TOF_W + PTR_W;
  localparam int CMP_W      = SUM_W + 10;
  localparam int MEAN_SH    = SUM_W + PTR_W;
  localparam longint MEAN_MUL = ((longint'(1) << MEAN_SH) + WINDOW - 1) / WINDOW;
  localparam int MEAN_MUL_W = SUM_W + 1;
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(WINDOW - 1);
  localparam logic [SUM_W-1:0] WIN_K    = SUM_W'(WINDOW);
  localparam int Q_DEPTH = 8;
  localparam int Q_PTR_W = 3;
  localparam int Q_CNT_W = 4;

  // configuration registers
  logic [THR_W-1:0] thr_r;
  logic [MM_W-1:0]  base_r;
  logic [SPD_W-1:0] speed_r;
  logic [MM_W-1:0]  yellow_r;
  logic [MM_W-1:0]  red_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_RST;
      base_r   <= BASE_RST;
      speed_r  <= SPEED_RST;
      yellow_r <= YELLOW_RST;
      red_r    <= RED_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_THRESHOLD: thr_r    <= cfg_data[THR_W-1:0];
        CFG_BASE:      base_r   <= cfg_data[MM_W-1:0];
        CFG_SPEED:     speed_r  <= cfg_data[SPD_W-1:0];
        CFG_YELLOW:    yellow_r <= cfg_data[MM_W-1:0];
        CFG_RED:       red_r    <= cfg_data[MM_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: input register
  logic             in_acc;
  logic             s1_v_r;
  logic             s1_act_r;
  logic [TOF_W-1:0] s1_tof_r;

  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_act_r <= in_tuser;
      s1_tof_r <= in_tdata;
    end
  end

  // ring state
  logic [TOF_W-1:0]  ring_mem [WINDOW];
  logic [WINDOW-1:0] ring_vld_r;
  logic [PTR_W-1:0]  wp_r;
  logic              full_r;
  logic [SUM_W-1:0]  sum_r;
  logic [TOF_W-1:0]  old_r;       // contents of the entry at wp_r
  logic [TOF_W-1:0]  rd_data_r;
  logic              rd_vld_r;
  logic              byp_r;
  logic [TOF_W-1:0]  byp_data_r;

  logic [TOF_W-1:0]  nxt_old;
  logic [SUM_W-1:0]  wx;
  logic [SUM_W-1:0]  dev;
  logic [CMP_W-1:0]  dev_scaled;
  logic [CMP_W-1:0]  sum_scaled;
  logic              reject;
  logic              put;
  logic [PTR_W-1:0]  wp_inc;
  logic [PTR_W-1:0]  wp_inc2;
  logic [PTR_W-1:0]  rd_addr;
  logic [SUM_W-1:0]  sum_nxt;

  // entry after wp_r, prefetched last cycle, with a bypass for a write to the same entry
  assign nxt_old = byp_r ? byp_data_r : (rd_vld_r ? rd_data_r : '0);

  always_comb begin
    wx         = SUM_W'(s1_tof_r) * WIN_K;
    dev        = (wx > sum_r) ? (wx - sum_r) : (sum_r - wx);
    dev_scaled = CMP_W'(dev) * CMP_W'(1000);
    sum_scaled = CMP_W'(thr_r) * CMP_W'(sum_r);
    reject     = (s1_act_r == ACT_MEASURE) && full_r && (dev_scaled > sum_scaled);
    put        = s1_v_r && !reject;
    wp_inc     = (wp_r == LAST_IDX) ? '0 : (wp_r + 1'b1);
    wp_inc2    = (wp_inc == LAST_IDX) ? '0 : (wp_inc + 1'b1);
    rd_addr    = put ? wp_inc2 : wp_inc;
    sum_nxt    = sum_r - SUM_W'(old_r) + SUM_W'(s1_tof_r);
  end

  always_ff @(posedge clk) begin
    if (put) begin
      ring_mem[wp_r] <= s1_tof_r;
    end
    rd_data_r  <= ring_mem[rd_addr];
    byp_data_r <= s1_tof_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
      wp_r       <= '0;
      full_r     <= 1'b0;
      sum_r      <= '0;
      old_r      <= '0;
      rd_vld_r   <= 1'b0;
      byp_r      <= 1'b0;
    end else begin
      rd_vld_r <= ring_vld_r[rd_addr];
      byp_r    <= put && (rd_addr == wp_r);
      if (put) begin
        ring_vld_r[wp_r] <= 1'b1;
        wp_r             <= wp_inc;
        sum_r            <= sum_nxt;
        old_r            <= nxt_old;
        if (wp_inc == '0) begin
          full_r <= 1'b1;
        end
      end
    end
  end

  // stage 2: sum before update and tof * speed
  logic              s2_v_r;
  logic              s2_acc_r;
  logic [SUM_W-1:0]  s2_sum_r;
  logic [PROD_W-1:0] s2_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r && (s1_act_r == ACT_MEASURE);
    end
  end

  always_ff @(posedge clk) begin
    s2_acc_r  <= !reject;
    s2_sum_r  <= sum_r;
    s2_prod_r <= PROD_W'(s1_tof_r) * PROD_W'(speed_r);
  end

  // stage 3: reciprocal divides for mean and air gap
  logic [SUM_W+MEAN_MUL_W-1:0]  mean_prod;
  logic [PROD_W+DIV_MUL_W-1:0]  dist_prod;
  logic [DIST_Q_W-1:0]          dist_q;
  logic [MM_W-1:0]              dist_sat;
  logic                         s3_v_r;
  logic                         s3_acc_r;
  logic [TOF_W-1:0]             s3_mean_r;
  logic [MM_W-1:0]              s3_dist_r;

  always_comb begin
    mean_prod = (SUM_W + MEAN_MUL_W)'(s2_sum_r) * (SUM_W + MEAN_MUL_W)'(MEAN_MUL);
    dist_prod = (PROD_W + DIV_MUL_W)'(s2_prod_r) * (PROD_W + DIV_MUL_W)'(DIV_MUL);
    dist_q    = dist_prod[DIV_SHIFT +: DIST_Q_W];
    dist_sat  = (dist_q > DIST_Q_W'(DIST_MAX)) ? DIST_MAX : dist_q[MM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_acc_r  <= s2_acc_r;
    s3_mean_r <= mean_prod[MEAN_SH +: TOF_W];
    s3_dist_r <= s2_acc_r ? dist_sat : '0;
  end

  // depth and alert, written into the result queue
  out_item_t        q_wdata;
  logic [MM_W-1:0]  depth;

  always_comb begin
    depth            = (base_r > s3_dist_r) ? (base_r - s3_dist_r) : '0;
    q_wdata.accepted = s3_acc_r;
    q_wdata.mean     = s3_mean_r;
    q_wdata.gap      = s3_dist_r;
    q_wdata.depth    = s3_acc_r ? depth : '0;
    if (!s3_acc_r || (depth < yellow_r)) begin
      q_wdata.alert = ALERT_GREEN;
    end else if (depth <= red_r) begin
      q_wdata.alert = ALERT_YELLOW;
    end else begin
      q_wdata.alert = ALERT_RED;
    end
  end

  // result queue
  out_item_t          q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] q_wp_r;
  logic [Q_PTR_W-1:0] q_rp_r;
  logic [Q_CNT_W-1:0] q_cnt_r;
  logic [Q_CNT_W-1:0] q_occ;
  logic               pop;
  out_item_t          q_head;

  assign pop    = out_tvalid && out_tready;
  assign q_head = q_mem[q_rp_r];
  // queued plus in flight, so every accepted transaction has a slot
  assign q_occ  = q_cnt_r + Q_CNT_W'(s1_v_r) + Q_CNT_W'(s2_v_r) + Q_CNT_W'(s3_v_r);

  assign in_tready  = q_occ < Q_CNT_W'(Q_DEPTH);
  assign out_tvalid = q_cnt_r != '0;
  assign out_tuser  = q_head.accepted;
  assign out_tdata  = {2'b00, q_head.alert, q_head.depth, q_head.gap, q_head.mean};

  always_ff @(posedge clk) begin
    if (s3_v_r) begin
      q_mem[q_wp_r] <= q_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (s3_v_r) begin
        q_wp_r <= q_wp_r + 1'b1;
      end
      if (pop) begin
        q_rp_r <= q_rp_r + 1'b1;
      end
      q_cnt_r <= q_cnt_r + Q_CNT_W'(s3_v_r) - Q_CNT_W'(pop);
    end
  end

endmodule

FILE: tb/moving_average_outlier_gate_depth_test.sv
// self-checking testbench for the moving-average outlier gate with depth alerts
`timescale 1ns / 1ps

module moving_average_outlier_gate_depth_test;
  import maog_pkg::*;

  localparam int RING_DEPTH = 12;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct {
    logic             act;
    logic [TOF_W-1:0] tof;
    bit               sync;
  } echo_item_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [TOF_W-1:0]       in_tdata = '0;   // [15:0] tof_us
  logic                   in_tuser = 1'b0; // [0] action
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [15:0] mean, [29:16] distance, [43:30] depth,
                                           // [45:44] alert
  logic                   out_tuser;       // [0] accepted
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  moving_average_outlier_gate_depth #(.WINDOW(RING_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // shadow of the block: register copies and the sample ring
  logic [THR_W-1:0] thr_permille;
  logic [MM_W-1:0]  base_mm;
  logic [SPD_W-1:0] speed_mps;
  logic [MM_W-1:0]  yellow_mm;
  logic [MM_W-1:0]  red_mm;
  logic [TOF_W-1:0] ring [RING_DEPTH];
  int unsigned      ring_ptr;
  bit               ring_full;
  logic [19:0]      ring_sum;

  echo_item_t     pending_echoes[$];
  out_item_t      expected_readings[$];
  echo_item_t     tx_item;
  out_item_t      want;
  bit             bursty;
  int unsigned    tx_gap, rx_stall, quiet_cycles;
  int unsigned    n_pushed, n_samples, n_preloads, n_checked, n_rejects, n_errors;

  function automatic void ring_insert(input logic [TOF_W-1:0] x);
    ring_sum = ring_sum - 20'(ring[ring_ptr]) + 20'(x);
    ring[ring_ptr] = x;
    ring_ptr = (ring_ptr + 1) % RING_DEPTH;
    if (ring_ptr == 0) ring_full = 1'b1;
  endfunction

  // works out the reading caused by one accepted sample, if any
  function automatic void predict_reading(input logic act, input logic [TOF_W-1:0] tof);
    out_item_t       r;
    longint unsigned scaled, dev, air_gap;
    logic [MM_W-1:0] depth;
    r = '0;
    r.mean = TOF_W'(ring_sum / RING_DEPTH);
    if (act == ACT_PRELOAD) begin
      ring_insert(tof);
      n_preloads++;
      return;
    end
    if (ring_full) begin
      scaled = RING_DEPTH * longint'(tof);
      dev = scaled > ring_sum ? scaled - ring_sum : ring_sum - scaled;
      if (dev * 1000 > longint'(thr_permille) * ring_sum) begin
        r.accepted = 1'b0;
        r.alert = ALERT_GREEN;
        expected_readings.push_back(r);
        n_rejects++;
        return;
      end
    end
    ring_insert(tof);
    air_gap = (longint'(tof) * speed_mps) / 2000;
    if (air_gap > DIST_MAX) air_gap = DIST_MAX;
    depth = base_mm > air_gap ? base_mm - MM_W'(air_gap) : '0;
    r.accepted = 1'b1;
    r.gap = MM_W'(air_gap);
    r.depth = depth;
    if (depth < yellow_mm) r.alert = ALERT_GREEN;
    else if (depth <= red_mm) r.alert = ALERT_YELLOW;
    else r.alert = ALERT_RED;
    expected_readings.push_back(r);
  endfunction

  function automatic void compare_field(input string what, input int unsigned exp_v,
                                        input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: reading %0d %s expected %0d got %0d", $time, n_checked, what, exp_v,
               got_v);
      n_errors++;
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_reading(in_tuser, in_tdata);
        n_samples++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_echoes.size() > 0 &&
                     !(pending_echoes[0].sync && expected_readings.size() > 0)) begin
          tx_item = pending_echoes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= tx_item.tof;
          in_tuser <= tx_item.act;
          if (bursty && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 4);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected reading, expected none got tdata %h tuser %b", $time,
                   out_tdata, out_tuser);
          n_errors++;
        end else begin
          want = expected_readings.pop_front();
          compare_field("accepted", want.accepted, out_tuser);
          compare_field("baseline_mean_us", want.mean, out_tdata[15:0]);
          compare_field("distance_mm", want.gap, out_tdata[29:16]);
          compare_field("depth_mm", want.depth, out_tdata[43:30]);
          compare_field("alert_level", want.alert, out_tdata[45:44]);
          n_checked++;
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else if (bursty && $urandom_range(0, 5) == 0) begin
        rx_stall = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("[moving_average_outlier_gate_depth] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_echo(input logic act, input longint tof, input bit sync = 1'b0);
    echo_item_t e;
    if (tof < 0) tof = 0;
    if (tof > 65535) tof = 65535;
    e.act = act;
    e.tof = TOF_W'(tof);
    e.sync = sync;
    pending_echoes.push_back(e);
    n_pushed++;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (n_samples != n_pushed || expected_readings.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    case (idx)
      CFG_THRESHOLD: thr_permille = value[THR_W-1:0];
      CFG_BASE:      base_mm = value[MM_W-1:0];
      CFG_SPEED:     speed_mps = value[SPD_W-1:0];
      CFG_YELLOW:    yellow_mm = value[MM_W-1:0];
      CFG_RED:       red_mm = value[MM_W-1:0];
      default: ;
    endcase
    if (last) cfg_valid <= 1'b0;
  endtask

  // junk above each register's width checks that only the low bits are taken
  task automatic set_registers(input int unsigned thr, input int unsigned base,
                               input int unsigned speed, input int unsigned yellow,
                               input int unsigned red, input bit junk);
    int unsigned j;
    j = junk ? $urandom : 0;
    write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr | (j << THR_W)), 1'b0);
    write_reg(CFG_BASE, CFG_DATA_W'(base | (j << MM_W)), 1'b0);
    write_reg(CFG_SPEED, CFG_DATA_W'(speed | (j << SPD_W)), 1'b0);
    write_reg(CFG_YELLOW, CFG_DATA_W'(yellow | (j << MM_W)), 1'b0);
    write_reg(CFG_RED, CFG_DATA_W'(red | (j << MM_W)), 1'b1);
  endtask

  // echo time at random, or one that lands the depth near an alert threshold or below the base
  function automatic longint pick_level();
    longint depth, gap;
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 65535);
      1: depth = longint'(yellow_mm) + $urandom_range(0, 40) - 20;
      2: depth = longint'(red_mm) + $urandom_range(0, 40) - 20;
      default: depth = $urandom_range(0, base_mm);
    endcase
    if (depth < 0) depth = 0;
    gap = base_mm > depth ? base_mm - depth : 0;
    return (gap * 2000) / speed_mps + $urandom_range(0, 7);
  endfunction

  task automatic queue_random(input int unsigned count);
    longint      level, span;
    int unsigned stop, i, r;
    stop = n_pushed + count;
    level = pick_level();
    while (n_pushed < stop) begin
      if ($urandom_range(0, 39) == 0) begin
        level = pick_level();
        // mostly refill the ring so the new level gets past the gate
        if ($urandom_range(0, 3) != 0) begin
          for (i = 0; i < RING_DEPTH; i++)
            queue_echo(ACT_PRELOAD, level + $urandom_range(0, level / 100 + 1) - level / 200);
        end
      end
      span = (level * thr_permille) / 800 + 2;
      r = $urandom_range(0, 99);
      if (r < 5) queue_echo(ACT_PRELOAD, level + $urandom_range(0, 2 * span) - span);
      else if (r < 13) queue_echo(ACT_MEASURE, $urandom_range(0, 65535));
      else if (r < 16) queue_echo(ACT_MEASURE, level);
      else queue_echo(ACT_MEASURE, level + $urandom_range(0, 2 * span) - span,
                      $urandom_range(0, 149) == 0);
    end
  endtask

  initial begin
    int i;
    thr_permille = THR_RST;
    base_mm = BASE_RST;
    speed_mps = SPEED_RST;
    yellow_mm = YELLOW_RST;
    red_mm = RED_RST;
    foreach (ring[k]) ring[k] = '0;
    ring_ptr = 0;
    ring_full = 1'b0;
    ring_sum = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty ring, warm-up, preload wrap, gate edge and far outliers
    bursty = 1'b1;
    queue_echo(ACT_MEASURE, 0);
    queue_echo(ACT_MEASURE, 65535);
    for (i = 0; i < RING_DEPTH; i++) queue_echo(ACT_PRELOAD, 1000);
    queue_echo(ACT_MEASURE, 1151);
    queue_echo(ACT_MEASURE, 1150);
    queue_echo(ACT_MEASURE, 65535);
    queue_echo(ACT_MEASURE, 0);
    queue_random(350);
    wait_idle();

    // exact divide by five so both alert boundaries can be hit on the dot
    set_registers(1000, 1000, 400, 100, 200, 1'b0);
    for (i = 0; i < RING_DEPTH; i++) queue_echo(ACT_PRELOAD, 4000);
    queue_echo(ACT_MEASURE, 4000);
    queue_echo(ACT_MEASURE, 3995);
    queue_echo(ACT_MEASURE, 4500, 1'b1);
    queue_echo(ACT_MEASURE, 4505);
    queue_random(350);
    wait_idle();

    // zero tolerance, widest base, top speed so the air gap saturates,
    // and yellow above red
    bursty = 1'b0;
    set_registers(0, 16383, 511, 500, 300, 1'b0);
    for (i = 0; i < RING_DEPTH; i++) queue_echo(ACT_PRELOAD, 65535);
    queue_echo(ACT_MEASURE, 65535);
    queue_random(250);
    wait_idle();

    bursty = 1'b1;
    set_registers(1023, 0, 300, 0, 0, 1'b1);
    queue_random(250);
    wait_idle();

    bursty = 1'b0;
    set_registers($urandom_range(0, 1023), $urandom_range(0, 10000), $urandom_range(300, 400),
                  $urandom_range(0, 10000), $urandom_range(0, 10000), 1'b1);
    queue_random(300);
    wait_idle();

    $display("ran %0d samples (%0d preloads) over five register settings", n_samples,
             n_preloads);
    $display("checked %0d readings, %0d of them rejected as outliers", n_checked, n_rejects);
    if (n_errors == 0) begin
      $display("[moving_average_outlier_gate_depth] OK");
    end else begin
      $display("[moving_average_outlier_gate_depth] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/maog_pkg.sv
rtl/core/moving_average_outlier_gate_depth.sv
tb/moving_average_outlier_gate_depth_test.sv
